// ===== src/mouse_click_and_move_ticker_assert.svh =====
// ----------------------------------------------------------------------------
// mouse click and move ticker assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef MOUSE_CLICK_AND_MOVE_TICKER_ASSERT_SVH
`define MOUSE_CLICK_AND_MOVE_TICKER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MCMT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication, consequent checked at the following edge
`define MCMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mcmt_pkg.sv =====
// ----------------------------------------------------------------------------
// mcmt_pkg
// shared types, codes and defaults of the mouse click and move ticker
// ----------------------------------------------------------------------------
package mcmt_pkg;

    // default build values
    localparam int DEF_AUTO_CLICK_TICKS = 8;
    localparam int DEF_MOVE_PRESCALE    = 4;
    localparam int DEF_ACCEL_STEPS      = 16;

    // fixed field widths
    localparam int MOVE_W  = 8;
    localparam int CLICK_W = 8;
    localparam int DWELL_W = 16;
    localparam int TIME_W  = 32;
    localparam int DBL_W   = 10;

    // reset value of click_time
    localparam logic [CLICK_W-1:0] CLICK_TIME_RST = 8'd8;

    // button bit positions
    localparam int BTN_LEFT   = 0;
    localparam int BTN_MIDDLE = 1;
    localparam int BTN_RIGHT  = 2;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_CLICK_TIME = 1'b0,
        CFG_AUTODWELL  = 1'b1
    } t_cfg_idx;

    // single click request codes
    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_LEFT   = 2'd1,
        REQ_RIGHT  = 2'd2,
        REQ_MIDDLE = 2'd3
    } t_click_req;

    // button status reported with each result
    typedef struct packed {
        logic [2:0] down;
        logic [2:0] changed;
    } t_btn_status;

endpackage

// ===== src/mouse_click_and_move_ticker.sv =====
// ----------------------------------------------------------------------------
// mouse_click_and_move_ticker
// per-tick mouse emulation: click timers, double click, autodwell, move ramp
// ----------------------------------------------------------------------------
// Every accepted item is one update tick and gives exactly one result item.
// The block takes one item per clock while o_stall is low and runs as a
// three-stage pipeline: an input register, a state stage that applies the
// tick to the timers, ramps and button levels and forms |move| * ramp, and a
// result stage that divides by ACCEL_STEPS with a constant reciprocal
// multiply. Results show on o_valid. The pipeline keeps moving while any
// stage has room, so a stalled result does not block items behind it until
// all three stages are full. Configuration (click_time, autodwell_ms) is
// written through i_cfg_we; the user must write it only while no item is in
// flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mouse_click_and_move_ticker
    import mcmt_pkg::*;
#(
    parameter int AUTO_CLICK_TICKS = DEF_AUTO_CLICK_TICKS,
    parameter int MOVE_PRESCALE    = DEF_MOVE_PRESCALE,
    parameter int ACCEL_STEPS      = DEF_ACCEL_STEPS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_idx,
    input  logic [DWELL_W-1:0]       i_cfg_data,

    // tick input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [TIME_W-1:0]        i_now_ms,
    input  logic signed [MOVE_W-1:0] i_move_x,
    input  logic signed [MOVE_W-1:0] i_move_y,
    input  logic                     i_restart_dwell,
    input  logic [1:0]               i_click_request,
    input  logic                     i_double_request,

    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_move_valid,
    output logic signed [MOVE_W-1:0] o_move_dx,
    output logic signed [MOVE_W-1:0] o_move_dy,
    output logic                     o_left_down,
    output logic                     o_middle_down,
    output logic                     o_right_down,
    output logic                     o_left_changed,
    output logic                     o_middle_changed,
    output logic                     o_right_changed
);

    localparam int RAMP_W = $clog2(ACCEL_STEPS + 1);
    localparam int PROD_W = MOVE_W + RAMP_W;

    // configuration registers
    logic [CLICK_W-1:0] r_click_time;
    logic [DWELL_W-1:0] r_autodwell_ms;

    // pipeline occupancy, one bit per stage
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;
    logic accept, adv, load3;

    // input register
    logic [TIME_W-1:0]        r_now_ms;
    logic signed [MOVE_W-1:0] r_move_x;
    logic signed [MOVE_W-1:0] r_move_y;
    logic                     r_restart_dwell;
    logic [1:0]               r_click_request;
    logic                     r_double_request;

    // state stage to result stage
    logic              s2_mv_valid;
    logic              s2_neg_x, s2_neg_y;
    logic [PROD_W-1:0] s2_mag_x, s2_mag_y;
    t_btn_status       s2_btn;
    t_btn_status       s3_btn;

    // a stage may load when it is empty or its content moves on this cycle
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign accept  = i_valid && en1;
    // the tick is applied to the state when it leaves the input register
    assign adv     = r_v1 && en2;
    assign load3   = r_v2 && en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now_ms         <= i_now_ms;
            r_move_x         <= i_move_x;
            r_move_y         <= i_move_y;
            r_restart_dwell  <= i_restart_dwell;
            r_click_request  <= i_click_request;
            r_double_request <= i_double_request;
        end
    end

    // configuration writes, upper data bits ignored for click_time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_time   <= CLICK_TIME_RST;
            r_autodwell_ms <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CLICK_TIME: r_click_time   <= i_cfg_data[CLICK_W-1:0];
                CFG_AUTODWELL:  r_autodwell_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mcmt_state #(
        .AUTO_CLICK_TICKS (AUTO_CLICK_TICKS),
        .MOVE_PRESCALE    (MOVE_PRESCALE),
        .ACCEL_STEPS      (ACCEL_STEPS)
    ) u_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_click_time     (r_click_time),
        .i_autodwell_ms   (r_autodwell_ms),
        .i_now_ms         (r_now_ms),
        .i_move_x         (r_move_x),
        .i_move_y         (r_move_y),
        .i_restart_dwell  (r_restart_dwell),
        .i_click_request  (r_click_request),
        .i_double_request (r_double_request),
        .o_mv_valid       (s2_mv_valid),
        .o_neg_x          (s2_neg_x),
        .o_mag_x          (s2_mag_x),
        .o_neg_y          (s2_neg_y),
        .o_mag_y          (s2_mag_y),
        .o_btn            (s2_btn)
    );

    mcmt_scale #(
        .ACCEL_STEPS (ACCEL_STEPS)
    ) u_scale (
        .i_clk        (i_clk),
        .i_load       (load3),
        .i_mv_valid   (s2_mv_valid),
        .i_neg_x      (s2_neg_x),
        .i_mag_x      (s2_mag_x),
        .i_neg_y      (s2_neg_y),
        .i_mag_y      (s2_mag_y),
        .i_btn        (s2_btn),
        .o_move_valid (o_move_valid),
        .o_move_dx    (o_move_dx),
        .o_move_dy    (o_move_dy),
        .o_btn        (s3_btn)
    );

    assign o_valid          = r_v3;
    assign o_left_down      = s3_btn.down[BTN_LEFT];
    assign o_middle_down    = s3_btn.down[BTN_MIDDLE];
    assign o_right_down     = s3_btn.down[BTN_RIGHT];
    assign o_left_changed   = s3_btn.changed[BTN_LEFT];
    assign o_middle_changed = s3_btn.changed[BTN_MIDDLE];
    assign o_right_changed  = s3_btn.changed[BTN_RIGHT];

endmodule

// ===== src/mcmt_state.sv =====
// ----------------------------------------------------------------------------
// mcmt_state
// tick state update: dwell, click timers, double click, move ramps
// ----------------------------------------------------------------------------
module mcmt_state
    import mcmt_pkg::*;
#(
    parameter int AUTO_CLICK_TICKS = DEF_AUTO_CLICK_TICKS,
    parameter int MOVE_PRESCALE    = DEF_MOVE_PRESCALE,
    parameter int ACCEL_STEPS      = DEF_ACCEL_STEPS,
    localparam int RAMP_W          = $clog2(ACCEL_STEPS + 1),
    localparam int PROD_W          = MOVE_W + RAMP_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic [CLICK_W-1:0]       i_click_time,
    input  logic [DWELL_W-1:0]       i_autodwell_ms,
    input  logic [TIME_W-1:0]        i_now_ms,
    input  logic signed [MOVE_W-1:0] i_move_x,
    input  logic signed [MOVE_W-1:0] i_move_y,
    input  logic                     i_restart_dwell,
    input  logic [1:0]               i_click_request,
    input  logic                     i_double_request,
    output logic                     o_mv_valid,
    output logic                     o_neg_x,
    output logic [PROD_W-1:0]        o_mag_x,
    output logic                     o_neg_y,
    output logic [PROD_W-1:0]        o_mag_y,
    output t_btn_status              o_btn
);

    localparam int PRE_W = (MOVE_PRESCALE > 1) ? $clog2(MOVE_PRESCALE) : 1;
    localparam int DBL_MAX = 3 * ((1 << CLICK_W) - 1);

    logic [RAMP_W-1:0]  r_ramp_x, n_ramp_x;
    logic [RAMP_W-1:0]  r_ramp_y, n_ramp_y;
    logic [PRE_W-1:0]   r_pre_cnt, n_pre_cnt;
    logic [CLICK_W-1:0] r_left_tmr, n_left_tmr;
    logic [CLICK_W-1:0] r_right_tmr, n_right_tmr;
    logic [CLICK_W-1:0] r_mid_tmr, n_mid_tmr;
    logic [DBL_W-1:0]   r_dbl_tmr, n_dbl_tmr;
    logic [2:0]         r_levels, n_levels;
    logic [TIME_W-1:0]  r_dwell_start, n_dwell_start;
    logic               r_armed, n_armed;

    logic               r_mv_valid, n_mv_valid;
    logic               r_neg_x, r_neg_y;
    logic [PROD_W-1:0]  r_mag_x, n_mag_x;
    logic [PROD_W-1:0]  r_mag_y, n_mag_y;
    t_btn_status        r_btn;

    logic [TIME_W-1:0]  dwell_elapsed;
    logic               dwell_fire;
    logic               any_move;
    logic [MOVE_W-1:0]  abs_x, abs_y;

    // magnitude of -128 is 128, still fits unsigned
    assign abs_x = i_move_x[MOVE_W-1] ? MOVE_W'(-i_move_x) : MOVE_W'(i_move_x);
    assign abs_y = i_move_y[MOVE_W-1] ? MOVE_W'(-i_move_y) : MOVE_W'(i_move_y);
    assign any_move = (i_move_x != '0) || (i_move_y != '0);

    always_comb begin
        n_ramp_x      = r_ramp_x;
        n_ramp_y      = r_ramp_y;
        n_pre_cnt     = r_pre_cnt;
        n_left_tmr    = r_left_tmr;
        n_right_tmr   = r_right_tmr;
        n_mid_tmr     = r_mid_tmr;
        n_dbl_tmr     = r_dbl_tmr;
        n_levels      = r_levels;
        n_dwell_start = r_dwell_start;
        n_armed       = r_armed;
        n_mv_valid    = 1'b0;

        // requests
        if (i_restart_dwell) begin
            n_dwell_start = i_now_ms;
            n_armed       = 1'b1;
        end
        case (t_click_req'(i_click_request))
            REQ_LEFT: begin
                n_levels[BTN_LEFT] = 1'b1;
                n_left_tmr         = i_click_time;
            end
            REQ_RIGHT: begin
                n_levels[BTN_RIGHT] = 1'b1;
                n_right_tmr         = i_click_time;
            end
            REQ_MIDDLE: begin
                n_levels[BTN_MIDDLE] = 1'b1;
                n_mid_tmr            = i_click_time;
            end
            default: ;
        endcase
        if (i_double_request) begin
            n_levels[BTN_LEFT] = 1'b1;
            n_dbl_tmr = {2'b00, i_click_time} + {1'b0, i_click_time, 1'b0};
        end

        // autodwell, wrapping elapsed time
        dwell_elapsed = i_now_ms - n_dwell_start;
        dwell_fire    = (i_autodwell_ms != '0) && n_armed &&
                        (dwell_elapsed >= {{(TIME_W-DWELL_W){1'b0}}, i_autodwell_ms});
        if (dwell_fire) begin
            n_levels[BTN_LEFT] = 1'b1;
            n_left_tmr         = CLICK_W'(AUTO_CLICK_TICKS);
            n_armed            = 1'b0;
        end

        // move ramp and prescaler
        if (i_move_x == '0) n_ramp_x = '0;
        if (i_move_y == '0) n_ramp_y = '0;
        if (any_move) begin
            n_mv_valid = (r_pre_cnt == '0);
            n_pre_cnt  = (r_pre_cnt == PRE_W'(MOVE_PRESCALE - 1)) ? '0
                                                                  : r_pre_cnt + 1'b1;
            if (n_mv_valid) begin
                if ((i_move_x != '0) && (n_ramp_x < RAMP_W'(ACCEL_STEPS)))
                    n_ramp_x = n_ramp_x + 1'b1;
                if ((i_move_y != '0) && (n_ramp_y < RAMP_W'(ACCEL_STEPS)))
                    n_ramp_y = n_ramp_y + 1'b1;
            end
        end
        n_mag_x = PROD_W'(abs_x) * PROD_W'(n_ramp_x);
        n_mag_y = PROD_W'(abs_y) * PROD_W'(n_ramp_y);

        // single click timers
        if (n_left_tmr != '0) begin
            n_left_tmr = n_left_tmr - 1'b1;
            if (n_left_tmr == '0) n_levels[BTN_LEFT] = 1'b0;
        end
        if (n_right_tmr != '0) begin
            n_right_tmr = n_right_tmr - 1'b1;
            if (n_right_tmr == '0) n_levels[BTN_RIGHT] = 1'b0;
        end
        if (n_mid_tmr != '0) begin
            n_mid_tmr = n_mid_tmr - 1'b1;
            if (n_mid_tmr == '0) n_levels[BTN_MIDDLE] = 1'b0;
        end

        // double click: up at two click times, down at one, up at zero
        if (n_dbl_tmr != '0) begin
            n_dbl_tmr = n_dbl_tmr - 1'b1;
            if (n_dbl_tmr == {1'b0, i_click_time, 1'b0})
                n_levels[BTN_LEFT] = 1'b0;
            else if (n_dbl_tmr == {2'b00, i_click_time})
                n_levels[BTN_LEFT] = 1'b1;
            else if (n_dbl_tmr == '0)
                n_levels[BTN_LEFT] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_x      <= '0;
            r_ramp_y      <= '0;
            r_pre_cnt     <= '0;
            r_left_tmr    <= '0;
            r_right_tmr   <= '0;
            r_mid_tmr     <= '0;
            r_dbl_tmr     <= '0;
            r_levels      <= '0;
            r_dwell_start <= '0;
            r_armed       <= 1'b0;
        end else if (i_adv) begin
            r_ramp_x      <= n_ramp_x;
            r_ramp_y      <= n_ramp_y;
            r_pre_cnt     <= n_pre_cnt;
            r_left_tmr    <= n_left_tmr;
            r_right_tmr   <= n_right_tmr;
            r_mid_tmr     <= n_mid_tmr;
            r_dbl_tmr     <= n_dbl_tmr;
            r_levels      <= n_levels;
            r_dwell_start <= n_dwell_start;
            r_armed       <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mv_valid    <= n_mv_valid;
            r_neg_x       <= i_move_x[MOVE_W-1];
            r_neg_y       <= i_move_y[MOVE_W-1];
            r_mag_x       <= n_mag_x;
            r_mag_y       <= n_mag_y;
            r_btn.down    <= n_levels;
            r_btn.changed <= n_levels ^ r_levels;
        end
    end

    assign o_mv_valid = r_mv_valid;
    assign o_neg_x    = r_neg_x;
    assign o_neg_y    = r_neg_y;
    assign o_mag_x    = r_mag_x;
    assign o_mag_y    = r_mag_y;
    assign o_btn      = r_btn;

`include "mouse_click_and_move_ticker_assert.svh"

    `MCMT_ASSERT_ALWAYS(a_ramp_bound,
        (r_ramp_x <= RAMP_W'(ACCEL_STEPS)) && (r_ramp_y <= RAMP_W'(ACCEL_STEPS)),
        "ramp above accel steps")
    `MCMT_ASSERT_ALWAYS(a_pre_bound, r_pre_cnt <= PRE_W'(MOVE_PRESCALE - 1),
        "prescale count out of range")
    `MCMT_ASSERT_ALWAYS(a_dbl_bound, r_dbl_tmr <= DBL_W'(DBL_MAX),
        "double click timer above three click times")
    `MCMT_ASSERT_NEXT(a_move_ramp, i_adv && n_mv_valid,
        (r_ramp_x != '0) || (r_ramp_y != '0), "move emitted with idle ramps")
    `MCMT_ASSERT_NEXT(a_changed, i_adv,
        r_btn.changed == (r_levels ^ $past(r_levels)), "change flags disagree with levels")

endmodule

// ===== src/mcmt_scale.sv =====
// ----------------------------------------------------------------------------
// mcmt_scale
// move scaling by reciprocal multiply and result register
// ----------------------------------------------------------------------------
module mcmt_scale
    import mcmt_pkg::*;
#(
    parameter int ACCEL_STEPS = DEF_ACCEL_STEPS,
    localparam int RAMP_W     = $clog2(ACCEL_STEPS + 1),
    localparam int PROD_W     = MOVE_W + RAMP_W
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic                     i_mv_valid,
    input  logic                     i_neg_x,
    input  logic [PROD_W-1:0]        i_mag_x,
    input  logic                     i_neg_y,
    input  logic [PROD_W-1:0]        i_mag_y,
    input  t_btn_status              i_btn,
    output logic                     o_move_valid,
    output logic signed [MOVE_W-1:0] o_move_dx,
    output logic signed [MOVE_W-1:0] o_move_dy,
    output t_btn_status              o_btn
);

    // floor(m / steps) == (m * ceil(2^k / steps)) >> k for all m < 2^PROD_W
    localparam int DIV_L   = $clog2(ACCEL_STEPS);
    localparam int DIV_K   = PROD_W + DIV_L;
    localparam int RECIP_W = DIV_K + 1;
    localparam int RECIP   = ((1 << DIV_K) + ACCEL_STEPS - 1) / ACCEL_STEPS;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic [MUL_W-1:0]  prod_x, prod_y;
    logic [MOVE_W-1:0] q_x, q_y;
    logic [MOVE_W-1:0] n_dx, n_dy;

    logic              r_move_valid;
    logic [MOVE_W-1:0] r_dx, r_dy;
    t_btn_status       r_btn;

    assign prod_x = MUL_W'(i_mag_x) * MUL_W'(RECIP_V);
    assign prod_y = MUL_W'(i_mag_y) * MUL_W'(RECIP_V);
    assign q_x    = prod_x[DIV_K +: MOVE_W];
    assign q_y    = prod_y[DIV_K +: MOVE_W];

    // sign applied after the unsigned quotient, so it truncates toward zero
    always_comb begin
        n_dx = '0;
        n_dy = '0;
        if (i_mv_valid) begin
            n_dx = i_neg_x ? MOVE_W'(MOVE_W'(0) - q_x) : q_x;
            n_dy = i_neg_y ? MOVE_W'(MOVE_W'(0) - q_y) : q_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_move_valid <= i_mv_valid;
            r_dx         <= n_dx;
            r_dy         <= n_dy;
            r_btn        <= i_btn;
        end
    end

    assign o_move_valid = r_move_valid;
    assign o_move_dx    = r_dx;
    assign o_move_dy    = r_dy;
    assign o_btn        = r_btn;

endmodule
